// File: hw/rtl/ip6tp_pkg.sv
`timescale 1ns / 1ps

package ip6tp_pkg;

    // Parser phases, one-hot
    typedef enum logic [6:0] {
        PH_START       = 7'b0000001,
        PH_LEAD        = 7'b0000010,
        PH_TOP         = 7'b0000100,
        PH_DIGITS      = 7'b0001000,
        PH_AFTER_COLON = 7'b0010000,
        PH_OCT_START   = 7'b0100000,
        PH_OCT_DIGITS  = 7'b1000000
    } t_phase;

    typedef logic [15:0] t_group;

    localparam int unsigned NUM_GROUPS = 8;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT   = 8'h2e;

    localparam logic [4:0]  HEX_NONE    = 5'd16;
    localparam logic [15:0] OCT1_MAX    = 16'h0255;
    localparam logic [7:0]  BCD_HI_MAX  = 8'h90;
    localparam logic [3:0]  BCD_LO_MAX  = 4'h9;
    localparam logic [11:0] OCT_MAX     = 12'd255;
    localparam logic [3:0]  GC_FULL     = 4'd8;
    localparam logic [3:0]  GC_V4_MAX   = 4'd6;

    // Digit value of a hex character, HEX_NONE if not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = HEX_NONE;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 5'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 5'(c - 8'h41 + 8'd10);
        end
        return v;
    endfunction

endpackage

// File: hw/rtl/ipv6_text_address_parser_core.sv
`timescale 1ns / 1ps
// Output: the result of a string is loaded into the output register on the edge that
//   accepts its terminating NUL and is presented from the next cycle on.
// Throughput: one character per cycle, NUL included; each character is one state update.
//   Any character stalls while a previous result still sits in the output register and
//   the result side is not ready to take it.
// Reset: synchronous active-low; parser returns to string start, output register empties.
module ipv6_text_address_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character channel
    input  logic        i_ch_valid,
    output logic        o_ch_ready,
    input  logic [7:0]  i_ch,
    // result channel
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [63:0] o_addr_hi,
    output logic [63:0] o_addr_lo,
    output logic        o_ok
);
    import ip6tp_pkg::*;

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    t_group     r_store [NUM_GROUPS];   // parsed groups, written at r_gc
    t_group     n_store [NUM_GROUPS];
    logic [3:0] r_gc, n_gc;             // groups stored so far (0..8)
    logic       r_gap, n_gap;           // double colon seen
    logic [3:0] r_gp, n_gp;             // index of the group after the double colon
    logic [15:0] r_hex, n_hex;          // current hex group
    logic [2:0] r_dc, n_dc;             // hex digit count, or IPv4 octet number
    logic [7:0] r_oct, n_oct;           // current decimal octet (never above 255)
    t_phase     r_phase, n_phase;
    logic       r_failed, n_failed;

    // Output register
    logic        r_out_valid;
    logic [63:0] r_addr_hi, r_addr_lo;
    logic        r_ok;

    // Per-character decode
    logic        acc;
    logic        is_nul, is_colon, is_dot, is_hex, is_dec;
    logic [4:0]  h;
    logic [11:0] oct_next;      // octet * 10 + digit
    logic [7:0]  oct1_val;      // first IPv4 octet, BCD converted
    logic [3:0]  gc_inc;
    logic [2:0]  widx;

    // Finish path
    logic        f_good;
    logic        f_add;         // final group / octet gets stored at r_gc
    t_group      f_entry;
    logic [3:0]  f_gc;
    t_group      f_e [NUM_GROUPS];
    t_group      f_g [NUM_GROUPS];

    // Input stalls only while an unread result holds the output register.
    assign o_ch_ready = !r_out_valid || i_res_ready;
    assign acc        = i_ch_valid && o_ch_ready;

    assign h        = hex_val(i_ch);
    assign is_nul   = (i_ch == CH_NUL);
    assign is_colon = (i_ch == CH_COLON);
    assign is_dot   = (i_ch == CH_DOT);
    assign is_hex   = (h != HEX_NONE);
    assign is_dec   = (h < 5'd10);
    assign oct_next = 12'({4'd0, r_oct} * 12'd10) + {8'd0, h[3:0]};
    assign oct1_val = 8'({6'd0, r_hex[9:8]} * 8'd100)
                    + 8'({4'd0, r_hex[7:4]} * 8'd10)
                    + {4'd0, r_hex[3:0]};
    assign gc_inc   = r_gc + 4'd1;
    assign widx     = r_gc[2:0];

    // ------------------------------------------------------------------
    // Next-state logic: one character per accepted transaction
    // ------------------------------------------------------------------
    always_comb begin
        logic do_top;
        do_top   = 1'b0;
        n_store  = r_store;
        n_gc     = r_gc;
        n_gap    = r_gap;
        n_gp     = r_gp;
        n_hex    = r_hex;
        n_dc     = r_dc;
        n_oct    = r_oct;
        n_phase  = r_phase;
        n_failed = r_failed;

        if (acc) begin
            if (is_nul) begin
                // string ends: back to string start (groups need no clearing)
                n_gc     = 4'd0;
                n_gap    = 1'b0;
                n_gp     = 4'd0;
                n_hex    = 16'd0;
                n_dc     = 3'd0;
                n_oct    = 8'd0;
                n_phase  = PH_START;
                n_failed = 1'b0;
            end else if (!r_failed) begin
                case (r_phase)
                    PH_START: begin
                        if (is_colon) begin
                            n_phase = PH_LEAD;
                        end else begin
                            do_top = 1'b1;
                        end
                    end
                    PH_LEAD: begin
                        if (is_colon) begin
                            n_store[0] = '0;
                            n_gc       = 4'd1;
                            n_gap      = 1'b1;
                            n_gp       = 4'd1;
                            n_phase    = PH_TOP;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_TOP, PH_AFTER_COLON: begin
                        do_top = 1'b1;
                    end
                    PH_DIGITS: begin
                        if (is_hex && r_dc < 3'd4) begin
                            n_hex = {r_hex[11:0], h[3:0]};
                            n_dc  = r_dc + 3'd1;
                        end else if (is_dot) begin
                            // first IPv4 octet: hex digits that must form BCD <= 255
                            if (r_gc > GC_V4_MAX || r_hex > OCT1_MAX
                                || {r_hex[7:4], 4'd0} > BCD_HI_MAX
                                || r_hex[3:0] > BCD_LO_MAX) begin
                                n_failed = 1'b1;
                            end else begin
                                n_store[widx] = {oct1_val, 8'd0};
                                n_dc          = 3'd1;
                                n_phase       = PH_OCT_START;
                            end
                        end else if (is_colon) begin
                            if (r_gc < GC_FULL) begin
                                n_store[widx] = r_hex;
                                n_gc          = gc_inc;
                            end else begin
                                n_failed = 1'b1;
                            end
                            n_phase = PH_AFTER_COLON;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_OCT_START: begin
                        if (is_dec) begin
                            n_oct   = {4'd0, h[3:0]};
                            n_phase = PH_OCT_DIGITS;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_OCT_DIGITS: begin
                        if (is_dec) begin
                            if (oct_next > OCT_MAX) begin
                                n_failed = 1'b1;
                            end else begin
                                n_oct = oct_next[7:0];
                            end
                        end else if (is_dot && r_dc == 3'd1 && r_gc < GC_FULL) begin
                            // second octet closes the low half of the group
                            n_store[widx] = r_store[widx] | {8'd0, r_oct};
                            n_gc          = gc_inc;
                            n_dc          = 3'd2;
                            n_phase       = PH_OCT_START;
                        end else if (is_dot && r_dc == 3'd2 && r_gc < GC_FULL) begin
                            n_store[widx] = {r_oct, 8'd0};
                            n_dc          = 3'd3;
                            n_phase       = PH_OCT_START;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    default: begin
                        n_failed = 1'b1;
                    end
                endcase

                // character at a group boundary
                if (do_top) begin
                    if (r_gc >= GC_FULL) begin
                        n_failed = 1'b1;
                    end else if (is_colon) begin
                        if (r_gap) begin
                            n_failed = 1'b1;
                        end else begin
                            n_store[widx] = '0;
                            n_gc          = gc_inc;
                            n_gap         = 1'b1;
                            n_gp          = gc_inc;
                            n_phase       = PH_TOP;
                        end
                    end else if (is_hex) begin
                        n_hex   = {12'd0, h[3:0]};
                        n_dc    = 3'd1;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // End of string: close the last group, check, stretch around the gap
    // ------------------------------------------------------------------
    always_comb begin
        f_good  = !r_failed;
        f_add   = 1'b0;
        f_entry = r_hex;
        case (r_phase)
            PH_START, PH_TOP: begin
            end
            PH_DIGITS: begin
                f_add = 1'b1;
                if (r_gc >= GC_FULL) begin
                    f_good = 1'b0;
                end
            end
            PH_OCT_DIGITS: begin
                f_add   = 1'b1;
                f_entry = r_store[widx] | {8'd0, r_oct};
                if (!(r_dc == 3'd3 && r_gc < GC_FULL)) begin
                    f_good = 1'b0;
                end
            end
            default: begin
                f_good = 1'b0;
            end
        endcase
        f_gc = (f_add && r_gc < GC_FULL) ? gc_inc : r_gc;
        if (!r_gap && f_gc != GC_FULL) begin
            f_good = 1'b0;
        end

        for (int k = 0; k < NUM_GROUPS; k++) begin
            f_e[k] = (f_add && widx == 3'(k)) ? f_entry : r_store[k];
        end

        // groups after the gap move to the top end: slot i takes entry (i + count) mod 8
        for (int i = 0; i < NUM_GROUPS; i++) begin
            if (!r_gap || 4'(i) < r_gp) begin
                f_g[i] = f_e[i];
            end else if ((5'(i) + {1'b0, f_gc}) >= (5'd8 + {1'b0, r_gp})) begin
                f_g[i] = f_e[3'(3'(i) + f_gc[2:0])];
            end else begin
                f_g[i] = '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gc     <= 4'd0;
            r_gap    <= 1'b0;
            r_gp     <= 4'd0;
            r_hex    <= 16'd0;
            r_dc     <= 3'd0;
            r_oct    <= 8'd0;
            r_phase  <= PH_START;
            r_failed <= 1'b0;
        end else begin
            r_gc     <= n_gc;
            r_gap    <= n_gap;
            r_gp     <= n_gp;
            r_hex    <= n_hex;
            r_dc     <= n_dc;
            r_oct    <= n_oct;
            r_phase  <= n_phase;
            r_failed <= n_failed;
        end
    end

    // group storage: payload, no reset
    always_ff @(posedge i_clk) begin
        r_store <= n_store;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc && is_nul) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && is_nul) begin
            r_ok      <= f_good;
            r_addr_hi <= f_good ? {f_g[0], f_g[1], f_g[2], f_g[3]} : 64'd0;
            r_addr_lo <= f_good ? {f_g[4], f_g[5], f_g[6], f_g[7]} : 64'd0;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_addr_hi   = r_addr_hi;
    assign o_addr_lo   = r_addr_lo;
    assign o_ok        = r_ok;

endmodule
